### rtl/core/assert_macros.svh
// assert_macros.svh - assertion wrappers for the core RTL.
// No dependencies; taken in by `include where a module checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// clocked check, switched off while reset is held
`define DWSC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// clocked check with no reset qualifier
`define DWSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DWSC_ASSERT(lbl, clk, rstn, prop, msg)
`define DWSC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/core/dwsc_pkg.sv
// dwsc_pkg.sv - constants, register indexes and lane control type for the
// dual-wheel PI speed control core. No dependencies.
`default_nettype none

package dwsc_pkg;

    localparam int PWM_PERIOD_COUNTS = 4000;
    localparam int TICK_MS           = 20;
    localparam int COUNT_BITS        = 16;
    localparam int FRAC_BITS         = 8;

    localparam int SPD_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int CNT_IN_W   = 16;
    localparam int CMP_W      = 12;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int ERR_W     = SPD_W + 1;
    localparam int PROD_W    = GAIN_W + ERR_W;
    localparam int INTEG_LIM = PWM_PERIOD_COUNTS * (2 ** FRAC_BITS);
    localparam int INTEG_W   = $clog2(INTEG_LIM + 1) + 1;
    localparam int SUM_W     = ((PROD_W > INTEG_W) ? PROD_W : INTEG_W) + 1;
    localparam int DUTY_W    = $clog2(PWM_PERIOD_COUNTS + 1);

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_TARGET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TARGET = 3'd4;

    localparam logic signed [GAIN_W-1:0] KP_RESET = 16'sd512;
    localparam logic signed [GAIN_W-1:0] KI_RESET = 16'sd128;

    // stage load strobes shared by both lanes, plus integral clear
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
        logic clr;
    } lane_ctl_t;

endpackage

`default_nettype wire

### rtl/core/dwsc_pi_lane.sv
// dwsc_pi_lane.sv - one wheel's PI lane: error, products, integral with
// anti-windup, duty clamp. Four stages. Depends on dwsc_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dwsc_pi_lane (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  dwsc_pkg::lane_ctl_t                   ctl,
    input  logic                                  en,
    input  logic signed [dwsc_pkg::SPD_W-1:0]     speed,
    input  logic signed [dwsc_pkg::SPD_W-1:0]     target,
    input  logic signed [dwsc_pkg::GAIN_W-1:0]    kp,
    input  logic signed [dwsc_pkg::GAIN_W-1:0]    ki,
    output logic                                  en_out,
    output logic signed [dwsc_pkg::SPD_W-1:0]     speed_out,
    output logic        [dwsc_pkg::DUTY_W-1:0]    duty_out
);

    localparam int ERR_W  = dwsc_pkg::ERR_W;
    localparam int PROD_W = dwsc_pkg::PROD_W;
    localparam int SUM_W  = dwsc_pkg::SUM_W;
    localparam int INT_W  = dwsc_pkg::INTEG_W;
    localparam int SPD_W  = dwsc_pkg::SPD_W;
    localparam int DUTY_W = dwsc_pkg::DUTY_W;

    localparam logic signed [SUM_W-1:0] LIM_S = SUM_W'(dwsc_pkg::INTEG_LIM);
    localparam logic signed [INT_W-1:0] LIM_I = INT_W'(dwsc_pkg::INTEG_LIM);
    localparam logic signed [SUM_W-1:0] PER_S = SUM_W'(dwsc_pkg::PWM_PERIOD_COUNTS);
    localparam logic [DUTY_W-1:0]       PER_D = DUTY_W'(dwsc_pkg::PWM_PERIOD_COUNTS);

    // stage 1
    logic                     en1_reg;
    logic signed [SPD_W-1:0]  spd1_reg;
    logic signed [ERR_W-1:0]  err1_reg;
    // stage 2
    logic                     en2_reg;
    logic signed [SPD_W-1:0]  spd2_reg;
    logic signed [PROD_W-1:0] kpp2_reg;
    logic signed [PROD_W-1:0] kip2_reg;
    // stage 3
    logic                     en3_reg;
    logic signed [SPD_W-1:0]  spd3_reg;
    logic signed [PROD_W-1:0] kpp3_reg;
    logic signed [INT_W-1:0]  integ_reg;
    // stage 4
    logic                     en4_reg;
    logic signed [SPD_W-1:0]  spd4_reg;
    logic        [DUTY_W-1:0] duty4_reg;

    logic signed [ERR_W-1:0]  err_next;
    logic signed [PROD_W-1:0] kp_prod;
    logic signed [PROD_W-1:0] ki_prod;
    logic signed [SUM_W-1:0]  integ_sum;
    logic signed [SUM_W-1:0]  integ_clamped;
    logic signed [INT_W-1:0]  integ_next;
    logic signed [SUM_W-1:0]  acc;
    logic signed [SUM_W-1:0]  quo;
    logic        [DUTY_W-1:0] duty_next;

    assign err_next = ERR_W'(target) - ERR_W'(speed);
    assign kp_prod  = PROD_W'(kp) * PROD_W'(err1_reg);
    assign ki_prod  = PROD_W'(ki) * PROD_W'(err1_reg);

    // anti-windup: clamp the running integral to +-period in Q8
    always_comb
    begin
        integ_sum = SUM_W'(integ_reg) + SUM_W'(kip2_reg);
        if (integ_sum > LIM_S)
            integ_clamped = LIM_S;
        else if (integ_sum < -LIM_S)
            integ_clamped = -LIM_S;
        else
            integ_clamped = integ_sum;
        integ_next = en2_reg ? integ_clamped[INT_W-1:0] : '0;
    end

    // negative sums truncate to zero or below, so the clamp covers them
    always_comb
    begin
        acc = SUM_W'(kpp3_reg) + SUM_W'(integ_reg);
        quo = acc >>> dwsc_pkg::FRAC_BITS;
        if (!en3_reg || acc[SUM_W-1] || (acc == '0))
            duty_next = '0;
        else if (quo > PER_S)
            duty_next = PER_D;
        else
            duty_next = quo[DUTY_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld1)
        begin
            en1_reg  <= en;
            spd1_reg <= speed;
            err1_reg <= err_next;
        end
        if (ctl.ld2)
        begin
            en2_reg  <= en1_reg;
            spd2_reg <= spd1_reg;
            kpp2_reg <= kp_prod;
            kip2_reg <= ki_prod;
        end
        if (ctl.ld3)
        begin
            en3_reg  <= en2_reg;
            spd3_reg <= spd2_reg;
            kpp3_reg <= kpp2_reg;
        end
        if (ctl.ld4)
        begin
            en4_reg   <= en3_reg;
            spd4_reg  <= spd3_reg;
            duty4_reg <= duty_next;
        end
    end

    // integral is loop state; stage 3 holds at most one tick, so stage 4
    // reads the value that tick left behind
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            integ_reg <= '0;
        else if (ctl.clr)
            integ_reg <= '0;
        else if (ctl.ld3)
            integ_reg <= integ_next;
    end

    assign en_out    = en4_reg;
    assign speed_out = spd4_reg;
    assign duty_out  = duty4_reg;

    `DWSC_ASSERT(a_integ_bound, clk, rst_n, (integ_reg <= LIM_I) && (integ_reg >= -LIM_I), "integral outside anti-windup limit")

endmodule

`default_nettype wire

### rtl/core/dual_wheel_pi_speed_control_unit.sv
// Dual-wheel PI speed control unit.
// Input channel in_valid/in_ready carries one control tick: left_count (raw
// left quadrature counter) and right_pulses (right pulses since last tick).
// Output channel out_valid/out_ready returns one result per tick: active,
// time_ms, measured speeds, inverted PWM compare values and driver pins.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) for
// enable, kp_gain, ki_gain, left_target, right_target; write it only while
// no tick is in flight. Gain/target writes and an enable rise clear both
// integrals.
// Two identical PI lanes (left, right) run side by side, each four stages:
// error, gain multiplies, integral update, duty clamp; a merge stage builds
// the result register. Throughput is one tick per cycle while out_ready
// does not hold the result back; each lane's integral register is the only
// loop and closes in one add and clamp.
// The pipeline collapses bubbles: while the result waits on out_ready the
// earlier stages keep filling, and in_ready drops only with all five full.
// Reset: enable 0, kp 2.0, ki 0.5, targets 0, integrals, last count and
// timestamp 0, pipeline empty.
// Depends on dwsc_pkg, dwsc_pi_lane, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dual_wheel_pi_speed_control_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [dwsc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dwsc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [dwsc_pkg::CNT_IN_W-1:0]          left_count,
    input  logic signed [dwsc_pkg::SPD_W-1:0]      right_pulses,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   active,
    output logic [dwsc_pkg::TIME_W-1:0]            time_ms,
    output logic signed [dwsc_pkg::SPD_W-1:0]      left_speed,
    output logic signed [dwsc_pkg::SPD_W-1:0]      right_speed,
    output logic [dwsc_pkg::CMP_W-1:0]             left_compare,
    output logic [dwsc_pkg::CMP_W-1:0]             right_compare,
    output logic                                   left_in1,
    output logic                                   left_in2,
    output logic                                   right_in1,
    output logic                                   right_in2
);

    localparam int SPD_W  = dwsc_pkg::SPD_W;
    localparam int CNT_W  = dwsc_pkg::COUNT_BITS;
    localparam int DX_W   = ((CNT_W > SPD_W) ? CNT_W : SPD_W) + 1;
    localparam int DUTY_W = dwsc_pkg::DUTY_W;
    localparam int CMP_W  = dwsc_pkg::CMP_W;
    localparam int SPD_MAX_I = (2 ** (SPD_W - 1)) - 1;

    localparam logic signed [DX_W-1:0] SPD_HI = DX_W'(SPD_MAX_I);
    localparam logic signed [DX_W-1:0] SPD_LO = DX_W'(-SPD_MAX_I - 1);
    localparam logic [DUTY_W-1:0] PER_D = DUTY_W'(dwsc_pkg::PWM_PERIOD_COUNTS);
    localparam logic [CMP_W-1:0]  CMP_STOP = CMP_W'(dwsc_pkg::PWM_PERIOD_COUNTS);
    localparam logic [dwsc_pkg::TIME_W-1:0] TICK_T = dwsc_pkg::TIME_W'(dwsc_pkg::TICK_MS);

    // configuration
    logic                                enable_reg;
    logic signed [dwsc_pkg::GAIN_W-1:0]  kp_reg;
    logic signed [dwsc_pkg::GAIN_W-1:0]  ki_reg;
    logic signed [SPD_W-1:0]             left_target_reg;
    logic signed [SPD_W-1:0]             right_target_reg;
    logic                                integ_clr;

    // tick state and pipeline control
    logic [dwsc_pkg::CNT_IN_W-1:0]       last_left_reg;
    logic [dwsc_pkg::TIME_W-1:0]         ts_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, adv_out, mv4, ld1;
    dwsc_pkg::lane_ctl_t                 lane_ctl;

    // left speed front end
    logic [CNT_W-1:0]        cnt_diff;
    logic signed [DX_W-1:0]  diff_x;
    logic signed [SPD_W-1:0] left_spd;
    logic signed [SPD_W-1:0] left_lane_spd;
    logic signed [SPD_W-1:0] right_lane_spd;

    // lane results
    logic                    l_en4, r_en4;
    logic signed [SPD_W-1:0] l_spd4, r_spd4;
    logic [DUTY_W-1:0]       l_duty4, r_duty4;

    // result register
    logic                    active_reg;
    logic signed [SPD_W-1:0] lspd_reg, rspd_reg;
    logic [CMP_W-1:0]        lcmp_reg, rcmp_reg;
    logic                    lin2_reg;

    always_comb
    begin
        integ_clr = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                dwsc_pkg::REG_ENABLE:       integ_clr = cfg_data[0] && !enable_reg;
                dwsc_pkg::REG_KP_GAIN,
                dwsc_pkg::REG_KI_GAIN,
                dwsc_pkg::REG_LEFT_TARGET,
                dwsc_pkg::REG_RIGHT_TARGET: integ_clr = 1'b1;
                default:                    integ_clr = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= 1'b0;
            kp_reg           <= dwsc_pkg::KP_RESET;
            ki_reg           <= dwsc_pkg::KI_RESET;
            left_target_reg  <= '0;
            right_target_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dwsc_pkg::REG_ENABLE:       enable_reg       <= cfg_data[0];
                dwsc_pkg::REG_KP_GAIN:      kp_reg           <= cfg_data;
                dwsc_pkg::REG_KI_GAIN:      ki_reg           <= cfg_data;
                dwsc_pkg::REG_LEFT_TARGET:  left_target_reg  <= cfg_data;
                dwsc_pkg::REG_RIGHT_TARGET: right_target_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // each stage loads when the one after it is empty or moving on
    assign adv_out = !out_valid_reg || out_ready;
    assign mv4     = v4_reg && adv_out;
    assign rdy4    = !v4_reg || adv_out;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign ld1     = in_valid && rdy1;

    assign lane_ctl.ld1 = ld1;
    assign lane_ctl.ld2 = v1_reg && rdy2;
    assign lane_ctl.ld3 = v2_reg && rdy3;
    assign lane_ctl.ld4 = v3_reg && rdy4;
    assign lane_ctl.clr = integ_clr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            last_left_reg <= '0;
            ts_reg        <= '0;
        end
        else
        begin
            v1_reg        <= ld1 || (v1_reg && !lane_ctl.ld2);
            v2_reg        <= lane_ctl.ld2 || (v2_reg && !lane_ctl.ld3);
            v3_reg        <= lane_ctl.ld3 || (v3_reg && !lane_ctl.ld4);
            v4_reg        <= lane_ctl.ld4 || (v4_reg && !mv4);
            out_valid_reg <= mv4 || (out_valid_reg && !out_ready);
            if (ld1 && enable_reg)
                last_left_reg <= left_count;
            // timestamp steps as each result lands, in tick order
            if (mv4)
                ts_reg <= ts_reg + TICK_T;
        end
    end

    // counter difference modulo 2^COUNT_BITS, sign-extended, saturated
    always_comb
    begin
        cnt_diff = CNT_W'(left_count) - CNT_W'(last_left_reg);
        diff_x   = DX_W'($signed(cnt_diff));
        if (diff_x > SPD_HI)
            left_spd = SPD_W'(SPD_HI);
        else if (diff_x < SPD_LO)
            left_spd = SPD_W'(SPD_LO);
        else
            left_spd = diff_x[SPD_W-1:0];
    end

    assign left_lane_spd  = enable_reg ? left_spd : '0;
    assign right_lane_spd = enable_reg ? right_pulses : '0;

    dwsc_pi_lane u_left_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (lane_ctl),
        .en        (enable_reg),
        .speed     (left_lane_spd),
        .target    (left_target_reg),
        .kp        (kp_reg),
        .ki        (ki_reg),
        .en_out    (l_en4),
        .speed_out (l_spd4),
        .duty_out  (l_duty4)
    );

    dwsc_pi_lane u_right_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (lane_ctl),
        .en        (enable_reg),
        .speed     (right_lane_spd),
        .target    (right_target_reg),
        .kp        (kp_reg),
        .ki        (ki_reg),
        .en_out    (r_en4),
        .speed_out (r_spd4),
        .duty_out  (r_duty4)
    );

    // merge: inverted compare values and left direction pins
    always_ff @(posedge clk)
    begin
        if (mv4)
        begin
            active_reg <= l_en4;
            lspd_reg   <= l_spd4;
            rspd_reg   <= r_spd4;
            lcmp_reg   <= CMP_W'(PER_D - l_duty4);
            rcmp_reg   <= CMP_W'(PER_D - r_duty4);
            lin2_reg   <= (l_duty4 != '0);
        end
    end

    assign out_valid     = out_valid_reg;
    assign active        = active_reg;
    assign time_ms       = ts_reg;
    assign left_speed    = lspd_reg;
    assign right_speed   = rspd_reg;
    assign left_compare  = lcmp_reg;
    assign right_compare = rcmp_reg;
    assign left_in1      = !lin2_reg;
    assign left_in2      = lin2_reg;
    assign right_in1     = 1'b1;
    assign right_in2     = 1'b0;

    `DWSC_ASSERT(a_stopped_result, clk, rst_n, (out_valid_reg && !active_reg) |-> ((lcmp_reg == CMP_STOP) && (rcmp_reg == CMP_STOP) && !lin2_reg), "stopped tick with motor drive")
    `DWSC_ASSERT(a_lanes_agree, clk, rst_n, v4_reg |-> (l_en4 == r_en4), "lanes disagree on enable")
    `DWSC_ASSERT(a_full_stall, clk, rst_n, (v1_reg && v2_reg && v3_reg && v4_reg && out_valid_reg && !out_ready) |-> !in_ready, "transfer accepted into full pipeline")

endmodule

`default_nettype wire
